FILE: rtl/core/ljfc_pkg.sv
package ljfc_pkg;

   // Width of every intermediate magnitude; all of them saturate at 2^62-1.
   localparam int VAL_W = 62;
   localparam logic [VAL_W-1:0] SAT_VAL = {VAL_W{1'b1}};

   localparam int FRAC_BITS_DEF = 16;

   // floor(x/10) for any 32-bit x is (x * DIV10_RECIP) >> DIV10_SHIFT.
   localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
   localparam int DIV10_SHIFT = 35;

   localparam logic signed [31:0] FORCE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] FORCE_MIN = 32'sh8000_0000;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ITER  = 2'd1;

   localparam logic [15:0] TOL_RESET     = 16'd1;
   localparam logic [11:0] MAX_ITER_RESET = 12'd1024;

endpackage

FILE: rtl/core/ljfc_qmul.sv
module ljfc_qmul import ljfc_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [VAL_W-1:0] a,
   input  logic [VAL_W-1:0] b,
   output logic             done,
   output logic [VAL_W-1:0] result
);

   logic [63:0]  a_ff, a_in, b_ff, b_in;
   logic [2:0]   k_ff, k_in;
   logic         run_ff, run_in;
   logic [63:0]  prod_ff, prod_in;
   logic [1:0]   pk_ff, pk_in;
   logic         pv_ff, pv_in;
   logic [127:0] acc_ff, acc_in;
   logic         done_ff, done_in;
   logic [31:0]  a_part, b_part;
   logic [127:0] addend;

   // One 32x32 partial product per cycle; it is added in the next cycle.
   assign a_part = k_ff[1] ? a_ff[63:32] : a_ff[31:0];
   assign b_part = k_ff[0] ? b_ff[63:32] : b_ff[31:0];

   always_comb begin
      case (2'(pk_ff[1] + pk_ff[0]))
         2'd0:    addend = {64'd0, prod_ff};
         2'd1:    addend = {32'd0, prod_ff, 32'd0};
         2'd2:    addend = {prod_ff, 64'd0};
         default: addend = '0;
      endcase
   end

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      k_in    = k_ff;
      run_in  = run_ff;
      prod_in = prod_ff;
      pk_in   = pk_ff;
      pv_in   = 1'b0;
      acc_in  = acc_ff;
      done_in = 1'b0;
      if (start) begin
         a_in   = 64'(a);
         b_in   = 64'(b);
         k_in   = '0;
         run_in = 1'b1;
         acc_in = '0;
      end else if (run_ff) begin
         if (k_ff != 3'd4) begin
            prod_in = 64'(a_part) * 64'(b_part);
            pk_in   = k_ff[1:0];
            pv_in   = 1'b1;
            k_in    = k_ff + 3'd1;
         end
         if (pv_ff) begin
            acc_in = acc_ff + addend;
         end
         if (k_ff == 3'd4 && pv_ff) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         pv_ff   <= 1'b0;
         done_ff <= 1'b0;
         k_ff    <= '0;
      end else begin
         run_ff  <= run_in;
         pv_ff   <= pv_in;
         done_ff <= done_in;
         k_ff    <= k_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      prod_ff <= prod_in;
      pk_ff   <= pk_in;
      acc_ff  <= acc_in;
   end

   assign done   = done_ff;
   assign result = (|acc_ff[127:VAL_W+FRAC_BITS]) ? SAT_VAL
                                                  : acc_ff[VAL_W+FRAC_BITS-1:FRAC_BITS];

endmodule

FILE: rtl/core/ljfc_qdiv.sv
module ljfc_qdiv import ljfc_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [VAL_W-1:0] dividend,
   input  logic [31:0]      divisor,
   output logic             done,
   output logic [VAL_W-1:0] result
);

   localparam int N  = VAL_W + FRAC_BITS;
   localparam int CW = $clog2(N + 1);

   logic [N-1:0]  dvd_ff, dvd_in, quo_ff, quo_in;
   logic [31:0]   rem_ff, rem_in, den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in, done_ff, done_in;
   logic [32:0]   trial;
   logic          fits;

   // Restoring division, one quotient bit per cycle, MSB first.
   assign trial = {rem_ff, dvd_ff[N-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in = {dividend, {FRAC_BITS{1'b0}}};
         quo_in = '0;
         rem_in = '0;
         den_in = divisor;
         cnt_in = CW'(N);
         run_in = 1'b1;
      end else if (run_ff) begin
         dvd_in = {dvd_ff[N-2:0], 1'b0};
         quo_in = {quo_ff[N-2:0], fits};
         rem_in = fits ? 32'(trial - {1'b0, den_ff}) : trial[31:0];
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done   = done_ff;
   assign result = (|quo_ff[N-1:VAL_W]) ? SAT_VAL : quo_ff[VAL_W-1:0];

endmodule

FILE: rtl/core/lj_force_cap_radius_search_top.sv
// Channel  Ports                                           Direction
// request  start, busy, req_well_depth/size/force_limit   in (busy out)
// result   rsp_valid, rsp_radius/iterations/hit_limit     out (one-cycle strobe)
// config   csr_valid, csr_ready, csr_index, csr_wdata     in (csr_ready out)
// A disabled pair goes from the start transfer to S_OUT, which registers the result strobe.
// Otherwise each search iteration runs two bit-serial divides and five multiplies, or none
// for an iteration at radius 0, for up to max_iterations iterations (at most 4095).
// busy is high from the start transfer until the result strobe; start is ignored meanwhile.
// Reset is synchronous; the receiver cannot stall the result strobe.
module lj_force_cap_radius_search_top import ljfc_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic signed [31:0]   req_well_depth,
   input  logic [31:0]          req_size,
   input  logic signed [31:0]   req_force_limit,
   output logic                 rsp_valid,
   output logic [31:0]          rsp_radius,
   output logic [11:0]          rsp_iterations,
   output logic                 rsp_hit_limit,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_wdata
);

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_INIT  = 9'b000000010,
      S_TOP   = 9'b000000100,
      S_DIVQ  = 9'b000001000,
      S_MUL   = 9'b000010000,
      S_DIVM  = 9'b000100000,
      S_UPD   = 9'b001000000,
      S_OUT   = 9'b010000000,
      S_SPARE = 9'b100000000
   } state_type;

   localparam logic [VAL_W-1:0] HALF = VAL_W'(1) << (FRAC_BITS - 1);

   state_type state_ff, state_in;
   logic [30:0]        eps_ff, eps_in;
   logic [31:0]        sigma_ff, sigma_in, rad_ff, rad_in;
   logic signed [31:0] cap_ff, cap_in, force_ff, force_in;
   logic signed [33:0] step_ff, step_in;
   logic [11:0]        cnt_ff, cnt_in, maxit_ff, maxit_in;
   logic               hit_ff, hit_in;
   logic [15:0]        tol_ff, tol_in;
   logic [VAL_W-1:0]   q_ff, q_in, q2_ff, q2_in, q4_ff, q4_in;
   logic [VAL_W-1:0]   f6_ff, f6_in, g_ff, g_in, m_ff, m_in;
   logic [2:0]         mop_ff, mop_in;
   logic               mgo_ff, mgo_in, dgo_ff, dgo_in;
   logic               rv_ff, rv_in, rh_ff, rh_in;
   logic [31:0]        rr_ff, rr_in;
   logic [11:0]        ri_ff, ri_in;

   logic [VAL_W-1:0]   mul_a, mul_b, mul_res, div_dvd, div_res, tmag, m48;
   logic               mul_done, div_done, f6_neg;
   logic [67:0]        m48_wide;
   logic [63:0]        prod10;
   logic signed [31:0] force_new;
   logic               flip;
   logic [33:0]        step_abs, half_step;
   logic signed [33:0] step_next;
   logic signed [32:0] diff;
   logic [32:0]        diff_abs;
   logic signed [34:0] rad_sum;
   logic               disabled;

   ljfc_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock(clock), .reset(reset), .start(mgo_ff), .a(mul_a), .b(mul_b),
      .done(mul_done), .result(mul_res)
   );

   ljfc_qdiv #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock(clock), .reset(reset), .start(dgo_ff), .dividend(div_dvd),
      .divisor(rad_ff), .done(div_done), .result(div_res)
   );

   assign f6_neg = f6_ff < HALF;
   assign tmag   = f6_neg ? HALF - f6_ff : f6_ff - HALF;

   always_comb begin
      case (mop_ff)
         3'd0:    begin mul_a = q_ff;  mul_b = q_ff;  end
         3'd1:    begin mul_a = q2_ff; mul_b = q2_ff; end
         3'd2:    begin mul_a = q4_ff; mul_b = q2_ff; end
         3'd3:    begin mul_a = f6_ff; mul_b = tmag;  end
         default: begin mul_a = VAL_W'(eps_ff); mul_b = g_ff; end
      endcase
   end

   assign m48_wide = ({6'd0, m_ff} << 5) + ({6'd0, m_ff} << 4);
   assign m48      = (m48_wide > {6'd0, SAT_VAL}) ? SAT_VAL : m48_wide[VAL_W-1:0];
   assign div_dvd  = (state_ff == S_DIVQ) ? VAL_W'(sigma_ff) : m48;

   always_comb begin
      if (f6_neg) begin
         force_new = (div_res > VAL_W'(33'h1_0000_0000 >> 1)) ? FORCE_MIN
                                                             : -$signed(div_res[31:0]);
      end else begin
         force_new = (div_res > VAL_W'(FORCE_MAX)) ? FORCE_MAX : $signed(div_res[31:0]);
      end
   end

   assign prod10 = 64'(sigma_ff) * 64'(DIV10_RECIP);

   // Search update: halve and reverse the step when the cap is crossed; zero it within tolerance.
   assign flip      = (step_ff < 0 && cap_ff < force_ff) || (step_ff > 0 && cap_ff > force_ff);
   assign step_abs  = (step_ff < 0) ? 34'(-step_ff) : 34'(step_ff);
   assign half_step = step_abs >> 1;
   assign diff      = 33'(force_ff) - 33'(cap_ff);
   assign diff_abs  = (diff < 0) ? 33'(-diff) : 33'(diff);
   always_comb begin
      step_next = step_ff;
      if (flip) begin
         step_next = (step_ff < 0) ? $signed(half_step) : -$signed(half_step);
      end
      if (diff_abs < 33'(tol_ff)) begin
         step_next = '0;
      end
   end
   assign rad_sum = $signed({3'b000, rad_ff}) + 35'(step_next);

   assign disabled = (req_force_limit <= 0) || (req_well_depth <= 0) || (req_size == 32'd0);

   always_comb begin
      state_in = state_ff;
      eps_in   = eps_ff;
      sigma_in = sigma_ff;
      cap_in   = cap_ff;
      rad_in   = rad_ff;
      step_in  = step_ff;
      cnt_in   = cnt_ff;
      hit_in   = hit_ff;
      force_in = force_ff;
      q_in     = q_ff;
      q2_in    = q2_ff;
      q4_in    = q4_ff;
      f6_in    = f6_ff;
      g_in     = g_ff;
      m_in     = m_ff;
      mop_in   = mop_ff;
      mgo_in   = 1'b0;
      dgo_in   = 1'b0;
      rv_in    = 1'b0;
      rr_in    = rr_ff;
      ri_in    = ri_ff;
      rh_in    = rh_ff;
      tol_in   = tol_ff;
      maxit_in = maxit_ff;
      if (csr_valid) begin
         if (csr_index == CSR_TOLERANCE) begin
            tol_in = csr_wdata;
         end else if (csr_index == CSR_MAX_ITER) begin
            maxit_in = csr_wdata[11:0];
         end
      end
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               eps_in   = req_well_depth[30:0];
               sigma_in = req_size;
               cap_in   = req_force_limit;
               cnt_in   = '0;
               hit_in   = 1'b0;
               step_in  = '0;
               rad_in   = disabled ? 32'd0 : req_size;
               state_in = disabled ? S_OUT : S_INIT;
            end
         end
         S_INIT: begin
            step_in  = -$signed(34'(prod10[63:DIV10_SHIFT]));
            state_in = S_TOP;
         end
         S_TOP: begin
            if (step_ff == 0) begin
               state_in = S_OUT;
            end else if (cnt_ff == maxit_ff) begin
               hit_in   = 1'b1;
               state_in = S_OUT;
            end else if (rad_ff == 32'd0) begin
               force_in = FORCE_MAX;
               state_in = S_UPD;
            end else begin
               dgo_in   = 1'b1;
               state_in = S_DIVQ;
            end
         end
         S_DIVQ: begin
            if (div_done) begin
               q_in     = div_res;
               mop_in   = '0;
               mgo_in   = 1'b1;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            if (mul_done) begin
               case (mop_ff)
                  3'd0:    q2_in = mul_res;
                  3'd1:    q4_in = mul_res;
                  3'd2:    f6_in = mul_res;
                  3'd3:    g_in  = mul_res;
                  default: m_in  = mul_res;
               endcase
               if (mop_ff == 3'd4) begin
                  dgo_in   = 1'b1;
                  state_in = S_DIVM;
               end else begin
                  mop_in = mop_ff + 3'd1;
                  mgo_in = 1'b1;
               end
            end
         end
         S_DIVM: begin
            if (div_done) begin
               force_in = force_new;
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            step_in = step_next;
            if (rad_sum < 0) begin
               rad_in = '0;
            end else if (rad_sum > 35'sh0_FFFF_FFFF) begin
               rad_in = 32'hFFFF_FFFF;
            end else begin
               rad_in = rad_sum[31:0];
            end
            cnt_in   = cnt_ff + 12'd1;
            state_in = S_TOP;
         end
         S_OUT: begin
            rv_in    = 1'b1;
            rr_in    = rad_ff;
            ri_in    = cnt_ff;
            rh_in    = hit_ff;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mgo_ff   <= 1'b0;
         dgo_ff   <= 1'b0;
         rv_ff    <= 1'b0;
         tol_ff   <= TOL_RESET;
         maxit_ff <= MAX_ITER_RESET;
      end else begin
         state_ff <= state_in;
         mgo_ff   <= mgo_in;
         dgo_ff   <= dgo_in;
         rv_ff    <= rv_in;
         tol_ff   <= tol_in;
         maxit_ff <= maxit_in;
      end
      eps_ff   <= eps_in;
      sigma_ff <= sigma_in;
      cap_ff   <= cap_in;
      rad_ff   <= rad_in;
      step_ff  <= step_in;
      cnt_ff   <= cnt_in;
      hit_ff   <= hit_in;
      force_ff <= force_in;
      q_ff     <= q_in;
      q2_ff    <= q2_in;
      q4_ff    <= q4_in;
      f6_ff    <= f6_in;
      g_ff     <= g_in;
      m_ff     <= m_in;
      mop_ff   <= mop_in;
      rr_ff    <= rr_in;
      ri_ff    <= ri_in;
      rh_ff    <= rh_in;
   end

   assign busy           = state_ff != S_IDLE;
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rv_ff;
   assign rsp_radius     = rr_ff;
   assign rsp_iterations = ri_ff;
   assign rsp_hit_limit  = rh_ff;

`ifndef NO_ASSERTIONS
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted item did not raise busy");
   a_one_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");
   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_iterations <= maxit_ff) else $error("iterations beyond limit");
   a_hit_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit_limit |-> rsp_iterations == maxit_ff)
      else $error("limit flag without reaching the limit");
`endif

endmodule
